/* rtl/core/lsema_pkg.sv */
// Shared types and constants for the line-sensor moving-average classifier.
// No dependencies; imported by every module under rtl/core.
package lsema_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int CH_BITS        = 3;
    localparam int ALPHA_BITS     = 11;
    localparam int COUNT_BITS     = 4;
    localparam int MV_BITS        = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;

    localparam int PROD_BITS      = ALPHA_BITS + SAMPLE_BITS;   // filter partial products
    localparam int MV_PROD_BITS   = SAMPLE_BITS + MV_BITS;      // filtered * reference_mv

    localparam int IN_TDATA_BITS  = 16;
    localparam int IN_TUSER_BITS  = 5;
    localparam int OUT_TDATA_BITS = 56;
    localparam int OUT_TUSER_BITS = 4;

    localparam int QUEUE_DEPTH    = 2;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
    localparam logic [ALPHA_BITS-1:0]  ALPHA_ONE  = 11'd1024;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = {COUNT_BITS{1'b1}};

    localparam logic [SAMPLE_BITS-1:0] DARK_THRESHOLD_RST  = 12'd2359;
    localparam logic [ALPHA_BITS-1:0]  EMA_ALPHA_RST       = 11'd307;
    localparam logic [COUNT_BITS-1:0]  LINE_MIN_COUNT_RST  = 4'd3;
    localparam logic [MV_BITS-1:0]     REFERENCE_MV_RST    = 13'd3300;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DARK_THRESHOLD  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EMA_ALPHA       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_MIN_COUNT  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REFERENCE_MV    = 2'd3;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] avg;
        logic [SAMPLE_BITS-1:0] mn;
        logic [SAMPLE_BITS-1:0] mx;
    } chan_state_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] dark_threshold;
        logic [ALPHA_BITS-1:0]  ema_alpha_q10;
        logic [COUNT_BITS-1:0]  line_min_count;
    } front_cfg_t;

    typedef struct packed {
        logic [CH_BITS-1:0]     channel;
        logic                   error;
        logic [SAMPLE_BITS-1:0] filtered;
        logic [SAMPLE_BITS-1:0] minimum;
        logic [SAMPLE_BITS-1:0] maximum;
        logic                   is_black;
        logic [COUNT_BITS-1:0]  dark_count;
        logic                   line_detected;
    } result_entry_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_FILT,
        F_WB
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_FIX
    } back_state_t;

endpackage

/* rtl/core/lsema_front.sv */
// Front end: accepts samples, updates the per-channel average/min/max store
// and the frame black count, pushes a partial result. Uses lsema_pkg.
module lsema_front
    import lsema_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CH_BITS-1:0]     in_channel,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   in_error,
    input  logic                   in_restart,
    input  logic                   in_frame_end,
    input  front_cfg_t             cfg,
    output logic                   push_valid,
    input  logic                   push_ready,
    output result_entry_t          push_entry
);

    localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_BITS = IDX_BITS + CH_BITS;

    front_state_t state_reg, state_next;

    chan_state_t store [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    logic [COUNT_BITS-1:0] count_reg;

    logic [CH_BITS-1:0]     ch_reg;
    logic [IDX_BITS-1:0]    addr_reg;
    logic [SAMPLE_BITS-1:0] raw_reg;
    logic                   err_reg;
    logic                   fend_reg;
    logic                   vld_reg;
    chan_state_t            mem_q_reg;
    logic [PROD_BITS-1:0]   p_new_reg;
    logic [PROD_BITS-1:0]   p_old_reg;
    logic                   old_zero_reg;
    logic [SAMPLE_BITS-1:0] filt_reg;

    logic [EXT_BITS-1:0]    ch_ext;
    logic [IDX_BITS-1:0]    addr_in;
    logic                   in_range;
    logic                   accept;
    logic                   push_fire;
    logic [ALPHA_BITS-1:0]  alpha_sat;
    logic [ALPHA_BITS-1:0]  alpha_rest;
    logic [SAMPLE_BITS-1:0] old_avg;
    logic [SAMPLE_BITS-1:0] min_old;
    logic [SAMPLE_BITS-1:0] max_old;
    logic [SAMPLE_BITS-1:0] min_new;
    logic [SAMPLE_BITS-1:0] max_new;
    logic [PROD_BITS-1:0]   ema_sum;
    logic                   black;
    logic [COUNT_BITS-1:0]  cnt_new;

    assign ch_ext   = {{IDX_BITS{1'b0}}, in_channel};
    assign addr_in  = ch_ext[IDX_BITS-1:0];
    assign in_range = (ch_ext < EXT_BITS'(CHANNELS));
    assign accept   = in_valid && in_ready;
    assign push_fire = push_valid && push_ready;

    assign alpha_sat  = (cfg.ema_alpha_q10 > ALPHA_ONE) ? ALPHA_ONE : cfg.ema_alpha_q10;
    assign alpha_rest = ALPHA_ONE - alpha_sat;
    assign old_avg    = vld_reg ? mem_q_reg.avg : '0;
    assign ema_sum    = p_new_reg + p_old_reg;

    // stored extremes of an entry not written since restart read as reset values
    assign min_old = vld_reg ? mem_q_reg.mn : SAMPLE_MAX;
    assign max_old = vld_reg ? mem_q_reg.mx : '0;
    assign min_new = (filt_reg < min_old) ? filt_reg : min_old;
    assign max_new = (filt_reg > max_old) ? filt_reg : max_old;

    assign black   = !err_reg && (filt_reg >= cfg.dark_threshold);
    assign cnt_new = (black && (count_reg != COUNT_MAX)) ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        push_entry.channel       = ch_reg;
        push_entry.error         = err_reg;
        push_entry.filtered      = err_reg ? '0 : filt_reg;
        push_entry.minimum       = err_reg ? '0 : min_new;
        push_entry.maximum       = err_reg ? '0 : max_new;
        push_entry.is_black      = black;
        push_entry.dark_count    = cnt_new;
        push_entry.line_detected = fend_reg && (cnt_new >= cfg.line_min_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_FILT;
            end
            F_FILT:
            begin
                state_next = F_WB;
            end
            F_WB:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // valid bits and frame count; restart clears them at the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (accept && in_restart)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (push_fire)
        begin
            if (!err_reg)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            count_reg <= fend_reg ? '0 : cnt_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_q_reg <= store[addr_in];
        end
        if (push_fire && !err_reg)
        begin
            store[addr_reg] <= '{avg: filt_reg, mn: min_new, mx: max_new};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= in_channel;
            addr_reg <= addr_in;
            raw_reg  <= in_sample;
            err_reg  <= in_error || !in_range;
            fend_reg <= in_frame_end;
            vld_reg  <= valid_reg[addr_in] && !in_restart;
        end
        if (state_reg == F_MUL)
        begin
            p_new_reg    <= PROD_BITS'(alpha_sat * raw_reg);
            p_old_reg    <= PROD_BITS'(alpha_rest * old_avg);
            old_zero_reg <= (old_avg == '0);
        end
        if (state_reg == F_FILT)
        begin
            filt_reg <= old_zero_reg ? raw_reg : ema_sum[SAMPLE_BITS+9:10];
        end
    end

endmodule

/* rtl/core/lsema_queue.sv */
// Small result queue between front end and back end.
// Uses lsema_pkg for the entry type and depth.
module lsema_queue
    import lsema_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  result_entry_t push_entry,
    output logic          pop_valid,
    input  logic          pop_ready,
    output result_entry_t pop_entry
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    result_entry_t slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic push_fire;
    logic pop_fire;

    assign push_ready = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/core/lsema_back.sv */
// Back end: millivolt conversion (multiply, divide by full scale) and the
// output register of the result stream. Uses lsema_pkg.
module lsema_back
    import lsema_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  result_entry_t             pop_entry,
    input  logic [MV_BITS-1:0]        reference_mv,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [OUT_TDATA_BITS-1:0] out_data,
    output logic [OUT_TUSER_BITS-1:0] out_user
);

    localparam int SUM_BITS = MV_PROD_BITS + 1;
    localparam int PAD_BITS = OUT_TDATA_BITS - (3 * SAMPLE_BITS + MV_BITS + COUNT_BITS + 2);

    back_state_t state_reg, state_next;

    result_entry_t            entry_reg;
    logic [MV_PROD_BITS-1:0]  prod_reg;
    logic [MV_BITS-1:0]       q0_reg;
    logic                     out_valid_reg;
    logic [OUT_TDATA_BITS-1:0] out_data_reg;
    logic [OUT_TUSER_BITS-1:0] out_user_reg;

    logic [SUM_BITS-1:0] q_sum;
    logic [SUM_BITS-1:0] rem;
    logic [MV_BITS-1:0]  mv;
    logic                load;

    // x/4095 estimated as (x + x/4096)/4096; low by at most one
    assign q_sum = {1'b0, prod_reg} + SUM_BITS'(prod_reg[MV_PROD_BITS-1:SAMPLE_BITS]);
    assign rem   = {1'b0, prod_reg} - {q0_reg, {SAMPLE_BITS{1'b0}}} + SUM_BITS'(q0_reg);
    assign mv    = (rem >= SUM_BITS'(SAMPLE_MAX)) ? q0_reg + 1'b1 : q0_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                state_next = B_FIX;
            end
            B_FIX:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            entry_reg <= pop_entry;
            prod_reg  <= MV_PROD_BITS'(pop_entry.filtered * reference_mv);
        end
        if (state_reg == B_DIV)
        begin
            q0_reg <= q_sum[MV_PROD_BITS-1:SAMPLE_BITS];
        end
        if (load)
        begin
            out_data_reg <= {{PAD_BITS{1'b0}},
                             entry_reg.line_detected,
                             entry_reg.dark_count,
                             entry_reg.is_black,
                             mv,
                             entry_reg.maximum,
                             entry_reg.minimum,
                             entry_reg.filtered};
            out_user_reg <= {entry_reg.error, entry_reg.channel};
        end
    end

endmodule

/* rtl/core/line_sensor_ema_classifier_unit.sv */
// Line-sensor moving-average classifier, top level. The front-end sequencer
// takes each sample through store read, filter multiply, filter sum and store
// write, and accepts no new sample until the last one is pushed to the queue.
// Reset restores register defaults; channel stores read as cleared through
// per-channel valid bits, so no clearing pass is run.
// Depends on lsema_pkg, lsema_front, lsema_queue, lsema_back.
module line_sensor_ema_classifier_unit
    import lsema_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]    s_axis_tdata,   // [11:0] sample
    input  logic [IN_TUSER_BITS-1:0]    s_axis_tuser,   // [2:0] channel, [3] sample_error,
                                                        // [4] restart
    input  logic                        s_axis_tlast,   // frame_end
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0]   m_axis_tdata,   // [11:0] filtered, [23:12] minimum,
                                                        // [35:24] maximum, [48:36] millivolts,
                                                        // [49] is_black, [53:50] dark count,
                                                        // [54] line_detected
    output logic [OUT_TUSER_BITS-1:0]   m_axis_tuser,   // [2:0] channel_out, [3] error_out
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

    logic [SAMPLE_BITS-1:0] dark_threshold_reg;
    logic [ALPHA_BITS-1:0]  ema_alpha_reg;
    logic [COUNT_BITS-1:0]  line_min_count_reg;
    logic [MV_BITS-1:0]     reference_mv_reg;

    front_cfg_t    front_cfg;
    logic          q_push_valid;
    logic          q_push_ready;
    result_entry_t q_push_entry;
    logic          q_pop_valid;
    logic          q_pop_ready;
    result_entry_t q_pop_entry;

    assign cfg_ready = 1'b1;

    assign front_cfg.dark_threshold = dark_threshold_reg;
    assign front_cfg.ema_alpha_q10  = ema_alpha_reg;
    assign front_cfg.line_min_count = line_min_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_threshold_reg  <= DARK_THRESHOLD_RST;
            ema_alpha_reg       <= EMA_ALPHA_RST;
            line_min_count_reg  <= LINE_MIN_COUNT_RST;
            reference_mv_reg    <= REFERENCE_MV_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DARK_THRESHOLD:  dark_threshold_reg  <= cfg_data[SAMPLE_BITS-1:0];
                REG_EMA_ALPHA:       ema_alpha_reg       <= cfg_data[ALPHA_BITS-1:0];
                REG_LINE_MIN_COUNT:  line_min_count_reg  <= cfg_data[COUNT_BITS-1:0];
                REG_REFERENCE_MV:    reference_mv_reg    <= cfg_data[MV_BITS-1:0];
                default:             ;
            endcase
        end
    end

    lsema_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_channel   (s_axis_tuser[CH_BITS-1:0]),
        .in_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_error     (s_axis_tuser[CH_BITS]),
        .in_restart   (s_axis_tuser[CH_BITS+1]),
        .in_frame_end (s_axis_tlast),
        .cfg          (front_cfg),
        .push_valid   (q_push_valid),
        .push_ready   (q_push_ready),
        .push_entry   (q_push_entry)
    );

    lsema_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_entry (q_push_entry),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_entry  (q_pop_entry)
    );

    lsema_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (q_pop_valid),
        .pop_ready    (q_pop_ready),
        .pop_entry    (q_pop_entry),
        .reference_mv (reference_mv_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_user     (m_axis_tuser)
    );

endmodule
